@@ design/assert_macros.svh @@
// assertion macros for the detector's rtl
// include in a module body; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
	label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed");
// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, cond)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ design/ir_pd_pkg.sv @@
// shared constants and types of the ir presence detector
// no dependencies
package ir_pd_pkg;

	localparam int DIFF_W     = 16;
	localparam int RING_DEPTH = 16;
	localparam int RING_SHIFT = 4;
	localparam int SUM_W      = DIFF_W + $clog2(RING_DEPTH);

	localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

	// configuration register indexes
	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD      = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HIT_TRIES      = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ACTIVATION_GAP = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_STARTUP_SCANS  = 2'd3;

	// register reset values
	localparam logic [15:0] THRESHOLD_RST      = 16'd100;
	localparam logic [7:0]  HIT_TRIES_RST      = 8'd3;
	localparam logic [7:0]  ACTIVATION_GAP_RST = 8'd10;
	localparam logic [7:0]  STARTUP_SCANS_RST  = 8'd16;

	// push of one difference into the ring
	typedef struct packed {
		logic              push;
		logic [DIFF_W-1:0] data;
	} ring_push_t;

endpackage

@@ design/ir_presence_detector_top.sv @@
// ir presence detector top level: input stage, scan control, result register
// depends on ir_pd_pkg, ir_pd_ring and assert_macros.svh
//
// Usage
//  Input channel: in_valid / in_stall carry one beat per pair of receiver
//  readings (emitter off, emitter on) with the cabinet_open and lockout bits.
//  Output channel: out_valid / out_stall carry one beat per finished scan.
//  A pair that continues a hit scan gives no beat.
//  Path: a pair that ends a scan passes the difference stage, then the scan
//  update writes the result register; out_stall can hold the pair in between.
//  Throughput: one pair per cycle while in_stall is low; the scan state and any
//  ring shift update in the same cycle a pair leaves the difference stage.
//  Configuration: cfg_we / cfg_addr / cfg_wdata write one register per cycle;
//  the user must write only while no pair is in flight (unenforced). Writing
//  startup_scans restarts startup. Reset: clears the ring, the running sum, the
//  scan and gap state and loads the registers with their defaults; no clearing
//  sweep is needed. Stall: while out_stall holds a result, one more pair may wait
//  in the difference stage; after that in_stall rises until the result is taken.
module ir_presence_detector_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [ir_pd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [15:0]                      cfg_wdata,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [15:0]                      reading_off,
	input  logic [15:0]                      reading_on,
	input  logic                             cabinet_open,
	input  logic                             lockout,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             activate,
	output logic                             hand_present,
	output logic [15:0]                      difference,
	output logic [15:0]                      baseline,
	output logic                             in_startup
);
	import ir_pd_pkg::*;

	`include "assert_macros.svh"

	// configuration registers
	logic [15:0] threshold_q;
	logic [7:0]  hit_tries_q;
	logic [7:0]  act_gap_q;
	logic [7:0]  startup_scans_q;

	// difference stage
	logic              valid_s1;
	logic [DIFF_W-1:0] diff_s1;
	logic              cab_s1;
	logic              lock_s1;

	// scan state
	logic [7:0]        hit_count_q;
	logic [DIFF_W-1:0] base_q;
	logic [7:0]        startup_left_q;
	logic [7:0]        gap_q;
	logic              hand_q;

	// result register
	logic              out_valid_q;
	logic              act_q;
	logic              hand_out_q;
	logic [DIFF_W-1:0] diff_q;
	logic [DIFF_W-1:0] base_out_q;
	logic              startup_out_q;

	logic              in_accept;
	logic              out_free;
	logic              fire2;
	logic [DIFF_W-1:0] ring_avg;
	logic [DIFF_W-1:0] scan_base;
	logic [DIFF_W:0]   limit;
	logic              hit;
	logic              cont;
	logic              startup;
	logic [7:0]        gap_dec;
	logic              act_c;
	logic              hand_nxt;
	logic [DIFF_W-1:0] diff_c;
	ring_push_t        ring_push;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign fire2     = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !fire2;
	assign in_accept = in_valid && !in_stall;

	// clamped on minus off
	assign diff_c = (reading_on > reading_off) ? (reading_on - reading_off) : '0;

	// difference stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			diff_s1 <= diff_c;
			cab_s1  <= cabinet_open;
			lock_s1 <= lockout;
		end
	end

	// scan decision
	always_comb begin
		scan_base = (hit_count_q == 8'd0) ? ring_avg : base_q;
		limit     = {1'b0, scan_base} + {1'b0, threshold_q};
		hit       = {1'b0, diff_s1} > limit;
		cont      = hit && (hit_count_q < hit_tries_q);
		startup   = startup_left_q != 8'd0;
		gap_dec   = (gap_q != 8'd0) ? gap_q - 8'd1 : 8'd0;
		act_c     = !startup && hit && !hand_q && !cab_s1 && !lock_s1 &&
		            (gap_dec == 8'd0);
		if (startup) begin
			hand_nxt = hand_q;
		end else if (hit) begin
			hand_nxt = hand_q || act_c;
		end else begin
			hand_nxt = 1'b0;
		end
		ring_push.push = fire2 && !cont && (startup || !hit);
		ring_push.data = diff_s1;
	end

	ir_pd_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ring_push),
		.avg    (ring_avg)
	);

	// scan state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= THRESHOLD_RST;
			hit_tries_q     <= HIT_TRIES_RST;
			act_gap_q       <= ACTIVATION_GAP_RST;
			startup_scans_q <= STARTUP_SCANS_RST;
			hit_count_q     <= '0;
			base_q          <= '0;
			startup_left_q  <= STARTUP_SCANS_RST;
			gap_q           <= '0;
			hand_q          <= 1'b0;
		end else begin
			if (fire2) begin
				base_q <= scan_base;
				if (cont) begin
					hit_count_q <= hit_count_q + 8'd1;
				end else begin
					hit_count_q <= '0;
					hand_q      <= hand_nxt;
					if (startup) begin
						startup_left_q <= startup_left_q - 8'd1;
					end else begin
						gap_q <= act_c ? act_gap_q : gap_dec;
					end
				end
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_THRESHOLD:      threshold_q <= cfg_wdata;
					REG_HIT_TRIES:      hit_tries_q <= cfg_wdata[7:0];
					REG_ACTIVATION_GAP: act_gap_q   <= cfg_wdata[7:0];
					REG_STARTUP_SCANS: begin
						startup_scans_q <= cfg_wdata[7:0];
						startup_left_q  <= cfg_wdata[7:0];
					end
					default: ;
				endcase
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire2 && !cont) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (fire2 && !cont) begin
			act_q         <= act_c;
			hand_out_q    <= hand_nxt;
			diff_q        <= diff_s1;
			base_out_q    <= scan_base;
			startup_out_q <= startup;
		end
	end

	assign out_valid    = out_valid_q;
	assign activate     = act_q;
	assign hand_present = hand_out_q;
	assign difference   = diff_q;
	assign baseline     = base_out_q;
	assign in_startup   = startup_out_q;

	// an activation always leaves the hand flag set and never falls in startup
	`ASSERT_IMPL(a_act_hand, clk, arst_n, out_valid_q && act_q,
		hand_out_q && !startup_out_q)
	// an activation reloads the gap counter
	`ASSERT_NEXT(a_gap_load, clk, arst_n, fire2 && !cont && act_c,
		gap_q == $past(act_gap_q))
	// the baseline stays latched while a scan is open
	`ASSERT_NEXT(a_base_hold, clk, arst_n, fire2 && (hit_count_q != 8'd0),
		base_q == $past(base_q))
	// the startup count never runs above the register
	`ASSERT_IMPL(a_startup_cap, clk, arst_n, startup_left_q > startup_scans_q, 1'b0)

endmodule

@@ design/ir_pd_cell.sv @@
// one cell of the difference ring: holds one stored difference
// depends on ir_pd_pkg
module ir_pd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  logic [ir_pd_pkg::DIFF_W-1:0] d,
	output logic [ir_pd_pkg::DIFF_W-1:0] q
);
	import ir_pd_pkg::*;

	logic [DIFF_W-1:0] val_q;

	// take the value on d on each push (the neighbour's, or the new difference at the head)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

@@ design/ir_pd_ring.sv @@
// chain of ring cells with running sum and rolling average
// depends on ir_pd_pkg and ir_pd_cell
module ir_pd_ring (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ir_pd_pkg::ring_push_t        push,
	output logic [ir_pd_pkg::DIFF_W-1:0] avg
);
	import ir_pd_pkg::*;

	logic [DIFF_W-1:0] cell_d [RING_DEPTH];
	logic [DIFF_W-1:0] cell_q [RING_DEPTH];
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  avg_full;

	// newest difference enters at the head, oldest drops off the tail
	assign cell_d[0] = push.data;

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign cell_d[i] = cell_q[i-1];
		end
		ir_pd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (push.push),
			.d      (cell_d[i]),
			.q      (cell_q[i])
		);
	end

	// running sum: add the new difference, drop the evicted one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (push.push) begin
			sum_q <= sum_q - SUM_W'(cell_q[RING_DEPTH-1]) + SUM_W'(push.data);
		end
	end

	// average with saturation
	assign avg_full = sum_q >> RING_SHIFT;
	assign avg = (avg_full > SUM_W'(DIFF_MAX)) ? DIFF_MAX : avg_full[DIFF_W-1:0];

endmodule

@@ dv/ir_presence_detector_top_tb.sv @@
`timescale 1ns / 100ps
// self-checking bench of the ir presence detector: directed and random reading-pair beats
// outcomes of each scan worked out in the bench and checked field by field on the result beats
// depends on ir_pd_pkg and ir_presence_detector_top
module ir_presence_detector_top_tb;
	import ir_pd_pkg::*;

	localparam int STUCK_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AT     = 500;

	typedef struct packed {
		logic [DIFF_W-1:0] off_level;
		logic [DIFF_W-1:0] on_level;
		logic              cab;
		logic              lock;
	} ir_pair_t;

	typedef struct packed {
		logic              act;
		logic              hand;
		logic [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0] base;
		logic              startup;
	} scan_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = REG_THRESHOLD;
	logic [15:0]           cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  activate;
	logic                  hand_present;
	logic [15:0]           difference;
	logic [15:0]           baseline;
	logic                  in_startup;

	ir_pair_t     offered = '0;
	ir_pair_t     pending_pairs[$];
	scan_result_t scan_results[$];
	int           pairs_taken = 0;
	int           mismatches  = 0;
	int           stuck_cycles = 0;
	int           hold_left = 0;
	logic         hold_done = 1'b0;
	logic         no_idle;

	// shadow of the registers and of the detector state
	logic [15:0]       thr_cfg;
	logic [7:0]        tries_cfg;
	logic [7:0]        gap_cfg;
	logic [7:0]        startup_cfg;
	logic [DIFF_W-1:0] ring_mem [RING_DEPTH];
	int                ring_ptr;
	logic [SUM_W-1:0]  ring_total;
	logic [DIFF_W-1:0] scan_base;
	logic [7:0]        tries_taken;
	logic [7:0]        startup_left;
	logic [7:0]        gap_left;
	logic              hand;

	assign no_idle = (pairs_taken >= 900) && (pairs_taken < 1100);

	ir_presence_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.reading_off  (offered.off_level),
		.reading_on   (offered.on_level),
		.cabinet_open (offered.cab),
		.lockout      (offered.lock),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.activate     (activate),
		.hand_present (hand_present),
		.difference   (difference),
		.baseline     (baseline),
		.in_startup   (in_startup)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// push one difference into the baseline ring
	function automatic void store_difference(input logic [DIFF_W-1:0] d);
		ring_total = ring_total - ring_mem[ring_ptr] + d;
		ring_mem[ring_ptr] = d;
		ring_ptr = (ring_ptr == RING_DEPTH - 1) ? 0 : ring_ptr + 1;
	endfunction

	// advance the scan by one reading pair, queue the outcome if the scan ends
	function automatic void predict_scan(input ir_pair_t p);
		scan_result_t      r;
		logic [DIFF_W-1:0] d;
		logic [SUM_W-1:0]  avg;
		logic              hit;
		if (tries_taken == 0) begin
			avg = ring_total >> RING_SHIFT;
			scan_base = (avg > SUM_W'(DIFF_MAX)) ? DIFF_MAX : avg[DIFF_W-1:0];
		end
		d = (p.on_level > p.off_level) ? p.on_level - p.off_level : '0;
		// 17-bit margin, never wraps
		hit = {1'b0, d} > ({1'b0, scan_base} + {1'b0, thr_cfg});
		if (hit && tries_taken < tries_cfg) begin
			tries_taken = tries_taken + 8'd1;
			return;
		end
		tries_taken = '0;
		r = '0;
		if (startup_left != 0) begin
			startup_left = startup_left - 8'd1;
			store_difference(d);
			r.startup = 1'b1;
		end else begin
			if (gap_left != 0)
				gap_left = gap_left - 8'd1;
			if (hit) begin
				// blocked hits leave ring and hand flag alone
				if (!hand && !p.cab && gap_left == 0 && !p.lock) begin
					r.act = 1'b1;
					hand = 1'b1;
					gap_left = gap_cfg;
				end
			end else begin
				store_difference(d);
				hand = 1'b0;
			end
		end
		r.hand = hand;
		r.diff = d;
		r.base = scan_base;
		scan_results.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// input beats: predict on acceptance, then offer the next pending pair
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_scan(offered);
				pairs_taken <= pairs_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_pairs.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
					offered <= pending_pairs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: one long hold-off, otherwise random idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && pairs_taken >= HOLD_AT) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 9);
		end
	end

	// result beats against the oldest expectation
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (scan_results.size() == 0) begin
				report_mismatch("unexpected result beat", 0, 1);
			end else begin
				want = scan_results.pop_front();
				if (activate !== want.act)
					report_mismatch("activate", want.act, activate);
				if (hand_present !== want.hand)
					report_mismatch("hand_present", want.hand, hand_present);
				if (difference !== want.diff)
					report_mismatch("difference", want.diff, difference);
				if (baseline !== want.base)
					report_mismatch("baseline", want.base, baseline);
				if (in_startup !== want.startup)
					report_mismatch("in_startup", want.startup, in_startup);
			end
		end
	end

	// watchdog on cycles without any beat or register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			REG_THRESHOLD:      thr_cfg = data;
			REG_HIT_TRIES:      tries_cfg = data[7:0];
			REG_ACTIVATION_GAP: gap_cfg = data[7:0];
			REG_STARTUP_SCANS: begin
				startup_cfg = data[7:0];
				startup_left = data[7:0];
			end
			default: ;
		endcase
	endtask

	// all four registers, junk in the unused upper bits of the narrow ones
	task automatic program_regs(input logic [15:0] t, input logic [7:0] h,
			input logic [7:0] g, input logic [7:0] s);
		write_reg(REG_THRESHOLD, t);
		write_reg(REG_HIT_TRIES, {8'($urandom), h});
		write_reg(REG_ACTIVATION_GAP, {8'($urandom), g});
		write_reg(REG_STARTUP_SCANS, {8'($urandom), s});
	endtask

	// wait for every beat to go and every result to arrive, then let the pipe settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || scan_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic push_pair(input int off, input int on, input logic cab, input logic lock);
		ir_pair_t p;
		p.off_level = off[15:0];
		p.on_level = on[15:0];
		p.cab = cab;
		p.lock = lock;
		pending_pairs.push_back(p);
	endtask

	// background level: small difference, sometimes negative
	task automatic queue_quiet();
		int off;
		off = $urandom_range(0, 65400);
		if ($urandom_range(3) == 0)
			push_pair(off, off - $urandom_range(0, (off < 300) ? off : 300), 1'b0, 1'b0);
		else
			push_pair(off, off + $urandom_range(0, 80), $urandom_range(99) < 5, 1'b0);
	endtask

	// hand in front of the sensor: large difference for len pairs
	task automatic queue_hand(input int len);
		int off;
		for (int i = 0; i < len; i++) begin
			off = $urandom_range(0, 1500);
			push_pair(off, $urandom_range(56000, 65535), $urandom_range(99) < 12,
				$urandom_range(99) < 12);
		end
	endtask

	// mixed traffic: quiet pairs, random pairs and hand runs mostly one whole scan long
	task automatic queue_traffic(input int n_pairs, input int burst);
		int queued;
		int kind;
		int len;
		queued = 0;
		while (queued < n_pairs) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				queue_quiet();
				queued++;
			end else if (kind < 85) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(1, burst + 2) : burst + 1;
				queue_hand(len);
				queued += len;
			end else begin
				push_pair($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
				queued++;
			end
		end
	endtask

	initial begin
		int tries;
		thr_cfg = THRESHOLD_RST;
		tries_cfg = HIT_TRIES_RST;
		gap_cfg = ACTIVATION_GAP_RST;
		startup_cfg = STARTUP_SCANS_RST;
		for (int i = 0; i < RING_DEPTH; i++)
			ring_mem[i] = '0;
		ring_ptr = 0;
		ring_total = '0;
		scan_base = '0;
		tries_taken = '0;
		startup_left = STARTUP_SCANS_RST;
		gap_left = '0;
		hand = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two startup scans, then activation and its blockers
		program_regs(16'd100, 8'd1, 8'd2, 8'd2);
		push_pair(65535, 0, 1'b0, 1'b0);      // clamped to zero, startup
		push_pair(0, 65535, 1'b0, 1'b0);      // hit continues the scan
		push_pair(0, 65535, 1'b0, 1'b0);      // startup hit still fills the ring
		push_pair(1000, 1000, 1'b0, 1'b0);    // miss
		queue_hand(0);
		push_pair(0, 40000, 1'b0, 1'b0);
		push_pair(0, 40000, 1'b0, 1'b0);      // activates
		push_pair(0, 40000, 1'b0, 1'b0);
		push_pair(0, 40000, 1'b0, 1'b0);      // hand already present
		push_pair(500, 510, 1'b0, 1'b0);      // miss clears hand
		push_pair(0, 40000, 1'b0, 1'b0);
		push_pair(0, 40000, 1'b1, 1'b0);      // cabinet open
		push_pair(0, 40000, 1'b0, 1'b0);
		push_pair(0, 40000, 1'b0, 1'b1);      // locked out
		push_pair(0, 40000, 1'b1, 1'b1);
		push_pair(0, 40000, 1'b0, 1'b0);      // only the last pair decides
		push_pair(7, 8, 1'b0, 1'b0);
		push_pair(0, 40000, 1'b0, 1'b0);
		push_pair(0, 40000, 1'b0, 1'b0);      // gap runs out on this scan
		push_pair(65535, 65535, 1'b0, 1'b0);
		push_pair(0, 0, 1'b1, 1'b1);
		push_pair(123, 124, 1'b0, 1'b0);
		wait_drained();

		// reset-like settings
		program_regs(THRESHOLD_RST, HIT_TRIES_RST, ACTIVATION_GAP_RST, STARTUP_SCANS_RST);
		queue_traffic(200, 3);
		wait_drained();

		// lowest settings everywhere
		program_regs(16'd0, 8'd0, 8'd0, 8'd0);
		queue_traffic(200, 0);
		wait_drained();

		// threshold at the top: no hits at all
		program_regs(16'hffff, 8'd1, 8'd255, 8'd4);
		queue_traffic(150, 1);
		wait_drained();

		// threshold, tries and gap only, startup left as it is
		write_reg(REG_THRESHOLD, 16'($urandom_range(200, 3000)));
		write_reg(REG_HIT_TRIES, {8'($urandom), 8'd2});
		write_reg(REG_ACTIVATION_GAP, {8'($urandom), 8'd5});
		queue_traffic(250, 2);
		wait_drained();

		// longest scans
		program_regs(16'd500, 8'd255, 8'd1, 8'd0);
		for (int i = 0; i < 20; i++)
			queue_quiet();
		queue_hand(256);
		queue_traffic(100, 4);
		wait_drained();

		// long startup
		program_regs(16'd300, 8'd1, 8'd3, 8'd200);
		queue_traffic(260, 1);
		wait_drained();

		// random settings
		for (int k = 0; k < 2; k++) begin
			tries = $urandom_range(0, 6);
			program_regs(16'($urandom_range(0, 4000)), 8'(tries), 8'($urandom_range(0, 20)),
				8'($urandom_range(0, 20)));
			queue_traffic(100, tries);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
